// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file vms_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define VMS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("vms assertion failed");

// Clocked assertion that is also checked during reset.
`define VMS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("vms assertion failed");

`endif

// ===== hw/rtl/vms_pkg.sv =====
package vms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 18;
    localparam int LEN_W    = 6;

    localparam logic [LEN_W-1:0] VEC_LEN_RST = 6'd32;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CAND  = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_SWEEP = 8'b0000_1000,
        ST_EVAL  = 8'b0001_0000,
        ST_ORD   = 8'b0010_0000,
        ST_OCALC = 8'b0100_0000,
        ST_OWAIT = 8'b1000_0000
    } state_t;

endpackage

// ===== hw/rtl/vector_median_subtract.sv =====
// Median subtraction over one vector of n samples (n = vec_len, clamped to 1..MAX_LEN).
// Samples are taken one per cycle while s_ready is high; the closing sample starts a
// rank-count median search over the buffer RAM (one RAM read per compare); each of the n
// results then goes through ST_ORD, ST_OCALC and ST_OWAIT, where it waits for m_ready.
// aresetn is synchronous, active low: clears control state and the sample count, sets
// vec_len to 32. The sample buffer is not cleared.
module vector_median_subtract #(
    parameter int MAX_LEN = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [vms_pkg::LEN_W-1:0]            cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vms_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vms_pkg::RESULT_W-1:0]  m_centered_x2,
    output logic                                 m_last
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = vms_pkg::SAMPLE_W;
    localparam int RW = vms_pkg::RESULT_W;

    vms_pkg::state_t state_reg, state_next;

    logic [vms_pkg::LEN_W-1:0] vec_len_reg;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [AW-1:0]  cand_idx_reg, cand_idx_next;
    logic [CW-1:0]  sweep_reg, sweep_next;
    logic [CW-1:0]  less_reg, less_next;
    logic [CW-1:0]  eq_reg, eq_next;
    logic [AW-1:0]  out_idx_reg, out_idx_next;
    logic [SW-1:0]  cand_val_reg, cand_val_next;
    logic [SW-1:0]  lo_reg, lo_next;
    logic [SW-1:0]  hi_reg, hi_next;
    logic           m_valid_reg, m_valid_next;
    logic [RW-1:0]  m_data_reg, m_data_next;
    logic           m_last_reg, m_last_next;

    logic           ram_we;
    logic [AW-1:0]  ram_raddr;
    logic [SW-1:0]  ram_rdata;

    logic [6:0]     eff_len;
    logic [CW-1:0]  fill_inc;
    logic [CW-1:0]  rank_lo, rank_hi;
    logic [CW:0]    rank_top;
    logic           hit_lo, hit_hi;
    logic [RW-1:0]  med2, samp2;

    always_comb begin
        if (vec_len_reg == '0) begin
            eff_len = 7'd1;
        end else if ({1'b0, vec_len_reg} > 7'(MAX_LEN)) begin
            eff_len = 7'(MAX_LEN);
        end else begin
            eff_len = {1'b0, vec_len_reg};
        end
    end

    assign s_ready  = (state_reg == vms_pkg::ST_IDLE);
    assign ram_we   = s_valid && s_ready;
    assign fill_inc = fill_reg + 1'b1;

    assign rank_lo  = (n_reg - 1'b1) >> 1;
    assign rank_hi  = n_reg >> 1;
    assign rank_top = {1'b0, less_reg} + {1'b0, eq_reg};
    assign hit_lo   = (less_reg <= rank_lo) && ({1'b0, rank_lo} < rank_top);
    assign hit_hi   = (less_reg <= rank_hi) && ({1'b0, rank_hi} < rank_top);

    assign med2  = {{2{lo_reg[SW-1]}}, lo_reg} + {{2{hi_reg[SW-1]}}, hi_reg};
    assign samp2 = {ram_rdata[SW-1], ram_rdata, 1'b0};

    vms_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (s_sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        cand_idx_next = cand_idx_reg;
        sweep_next    = sweep_reg;
        less_next     = less_reg;
        eq_next       = eq_reg;
        out_idx_next  = out_idx_reg;
        cand_val_next = cand_val_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        ram_raddr     = cand_idx_reg;

        unique case (state_reg)
            vms_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (7'(fill_inc) >= eff_len) begin
                        n_next        = fill_inc;
                        cand_idx_next = '0;
                        state_next    = vms_pkg::ST_CAND;
                    end else begin
                        fill_next = fill_inc;
                    end
                end
            end
            vms_pkg::ST_CAND: begin
                ram_raddr  = cand_idx_reg;
                state_next = vms_pkg::ST_LOAD;
            end
            vms_pkg::ST_LOAD: begin
                cand_val_next = ram_rdata;
                ram_raddr     = '0;
                sweep_next    = CW'(1);
                less_next     = '0;
                eq_next       = '0;
                state_next    = vms_pkg::ST_SWEEP;
            end
            vms_pkg::ST_SWEEP: begin
                ram_raddr = sweep_reg[AW-1:0];
                if ($signed(ram_rdata) < $signed(cand_val_reg)) begin
                    less_next = less_reg + 1'b1;
                end
                if (ram_rdata == cand_val_reg) begin
                    eq_next = eq_reg + 1'b1;
                end
                if (sweep_reg == n_reg) begin
                    state_next = vms_pkg::ST_EVAL;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            vms_pkg::ST_EVAL: begin
                if (hit_lo) begin
                    lo_next = cand_val_reg;
                end
                if (hit_hi) begin
                    hi_next = cand_val_reg;
                end
                if (CW'(cand_idx_reg) == n_reg - 1'b1) begin
                    out_idx_next = '0;
                    state_next   = vms_pkg::ST_ORD;
                end else begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = vms_pkg::ST_CAND;
                end
            end
            vms_pkg::ST_ORD: begin
                ram_raddr  = out_idx_reg;
                state_next = vms_pkg::ST_OCALC;
            end
            vms_pkg::ST_OCALC: begin
                m_data_next  = samp2 - med2;
                m_last_next  = (CW'(out_idx_reg) == n_reg - 1'b1);
                m_valid_next = 1'b1;
                state_next   = vms_pkg::ST_OWAIT;
            end
            vms_pkg::ST_OWAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        fill_next  = '0;
                        state_next = vms_pkg::ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = vms_pkg::ST_ORD;
                    end
                end
            end
            default: begin
                state_next = vms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vms_pkg::ST_IDLE;
            vec_len_reg <= vms_pkg::VEC_LEN_RST;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                vec_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        cand_idx_reg <= cand_idx_next;
        sweep_reg    <= sweep_next;
        less_reg     <= less_next;
        eq_reg       <= eq_next;
        out_idx_reg  <= out_idx_next;
        cand_val_reg <= cand_val_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_centered_x2 = m_data_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== hw/rtl/vms_ram.sv =====
module vms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/vms_checker.sv =====
`include "assert_macros.svh"

module vms_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [vms_pkg::RESULT_W-1:0]  m_centered_x2,
    input logic                          m_last
);

    // stalled result transaction holds
    `VMS_ASSERT(a_m_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_centered_x2) && $stable(m_last)))
    // no input is taken while results are pending
    `VMS_ASSERT(a_no_overlap, aclk, aresetn, !(s_ready && m_valid))
    // input reopens right after the final result
    `VMS_ASSERT(a_reopen, aclk, aresetn, (m_valid && m_ready && m_last) |=> s_ready)
    // a result never shows the cycle after an input transaction
    `VMS_ASSERT(a_no_early, aclk, aresetn, (s_valid && s_ready) |=> !m_valid)

endmodule

bind vector_median_subtract vms_checker u_vms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_centered_x2 (m_centered_x2),
    .m_last        (m_last)
);
